// ===== hw/rtl/sync_word_hunter_top_assert.svh =====
// ----------------------------------------------------------------------------
// sync word hunter assertion macros
// shared concurrent assertion forms, clocked on clock and gated by reset
// ----------------------------------------------------------------------------
`ifndef SYNC_WORD_HUNTER_TOP_ASSERT_SVH
`define SYNC_WORD_HUNTER_TOP_ASSERT_SVH

// same-cycle implication
`define SWH_ASSERT_NOW(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication
`define SWH_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== hw/rtl/swh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swh_pkg
// shared types, codes and helper functions of the sync word hunter
// ----------------------------------------------------------------------------
package swh_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam logic [31:0] SYNC_WORD_RESET = 32'h352E_F853;
   localparam logic [31:0] REPORT_MAX = 32'hFFFF_FFFF;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [1:0] {
      STATUS_FOUND    = 2'd0,
      STATUS_END_HUNT = 2'd1,
      STATUS_END_SKIP = 2'd2
   } status_type;

   typedef enum logic {
      CSR_SYNC_WORD   = 1'b0,
      CSR_HEADER_SKIP = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic       end_of_input;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] excess_nonzero;
      logic [31:0] excess_bytes;
   } result_type;

   typedef struct packed {
      logic       skipping;
      logic [1:0] match_position;
   } hunt_state_type;

   // saturating add of a small increment
   function automatic count_type sat_add(count_type a, logic [2:0] b);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, a} + (COUNT_WIDTH+1)'(b);
      return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
   endfunction

   // clamp a count to the 32-bit report field
   function automatic logic [31:0] report_sat(count_type c);
      logic [COUNT_WIDTH+31:0] e;
      e = (COUNT_WIDTH+32)'(c);
      return (e > (COUNT_WIDTH+32)'(REPORT_MAX)) ? REPORT_MAX : e[31:0];
   endfunction

   // nonzero sync bytes among the first n already matched
   function automatic logic [2:0] matched_nonzero(logic [31:0] word, logic [1:0] n);
      logic [2:0] c;
      c = 3'd0;
      for (int i = 0; i < 3; i++) begin
         if ((i < int'(n)) && (word[31-8*i -: 8] != 8'd0)) begin
            c = c + 3'd1;
         end
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/sync_word_hunter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_word_hunter_top
// hunts a byte stream for a 4-byte sync word, skips a header and reports
// the byte counts ahead of it
// ----------------------------------------------------------------------------
//
//   channel   direction   carries
//   req_*     in          one stream byte or an end-of-input marker per item
//   rsp_*     out         status and both saturating counts, zero or one per item
//   csr_*     in          register writes: sync word, header skip length
//
// one item per cycle sustained while the result register is not stalled; an item
// waits in the input register, and its result, if any, goes to the result register
// the limit is the state update loop in the core (compare, two
// saturating adds)
// synchronous active-high reset clears the hunt state, counters and both
// valid flags; the sync word returns to 0x352EF853, the skip length to zero
// a stalled result holds the input register, whether or not the held item
// would emit, so the input stalls once that register is occupied
//
`include "sync_word_hunter_top_assert.svh"

module sync_word_hunter_top (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] end_of_input
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] excess_bytes, [63:32] excess_nonzero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // register writes
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import swh_pkg::*;

   // configuration registers
   logic [31:0] sync_word_ff, sync_word_in;
   logic [3:0]  header_skip_ff, header_skip_in;

   item_type       req_item, held_item;
   logic           held_valid;
   logic           advance;
   logic           emit;
   result_type     core_result, out_result;
   hunt_state_type hunt_state;

   always_comb begin
      sync_word_in   = sync_word_ff;
      header_skip_in = header_skip_ff;
      if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_SYNC_WORD:   sync_word_in   = csr_wdata;
            CSR_HEADER_SKIP: header_skip_in = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff   <= SYNC_WORD_RESET;
         header_skip_ff <= 4'd0;
      end else begin
         sync_word_ff   <= sync_word_in;
         header_skip_ff <= header_skip_in;
      end
   end

   assign req_item.data_byte    = req_tdata;
   assign req_item.end_of_input = req_tuser;

   // the held item moves on when the result register is free or draining
   assign advance = held_valid && (!rsp_tvalid || rsp_tready);

   swh_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .held_valid (held_valid),
      .held_item  (held_item),
      .advance    (advance)
   );

   swh_core u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item        (held_item),
      .sync_word   (sync_word_ff),
      .header_skip (header_skip_ff),
      .emit        (emit),
      .result      (core_result),
      .hunt_state  (hunt_state)
   );

   swh_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (advance && emit),
      .load_result (core_result),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_result  (out_result)
   );

   assign rsp_tdata = {out_result.excess_nonzero, out_result.excess_bytes};
   assign rsp_tuser = out_result.status;

   // no unused status code ever leaves the block
   `SWH_ASSERT_NOW(a_status_code, rsp_tvalid, rsp_tuser != 2'd3, "undefined status code")
   // while skipping the header no partial match may be pending
   `SWH_ASSERT_NOW(a_skip_pos, hunt_state.skipping, hunt_state.match_position == 2'd0,
      "match position set while skipping header")
   // a stalled result is never overwritten by a new one
   `SWH_ASSERT_NOW(a_no_overwrite, rsp_tvalid && !rsp_tready, !advance,
      "held item advanced over a stalled result")
   // an emitted result shows up on the port next cycle
   `SWH_ASSERT_NEXT(a_emit_shown, advance && emit, rsp_tvalid, "emitted result lost")

endmodule

// ===== hw/rtl/swh_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swh_in_stage
// input register of the hunter, one item deep
// ----------------------------------------------------------------------------
module swh_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  swh_pkg::item_type in_item,
   output logic              held_valid,
   output swh_pkg::item_type held_item,
   input  logic              advance
);
   import swh_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   assign in_ready = !valid_ff || advance;
   assign valid_in = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

// ===== hw/rtl/swh_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swh_core
// hunt state, byte compare and saturating counters, one item per cycle while advance is high
// ----------------------------------------------------------------------------
module swh_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  swh_pkg::item_type       item,
   input  logic [31:0]             sync_word,
   input  logic [3:0]              header_skip,
   output logic                    emit,
   output swh_pkg::result_type     result,
   output swh_pkg::hunt_state_type hunt_state
);
   import swh_pkg::*;

   logic [1:0] pos_ff, pos_in;
   logic       skipping_ff, skipping_in;
   logic [3:0] skip_cnt_ff, skip_cnt_in;
   count_type  excess_ff, excess_in;
   count_type  nonzero_ff, nonzero_in;

   logic [7:0] expect_byte;
   logic [3:0] skip_dec;
   count_type  rep_excess, rep_nonzero;
   status_type status;

   assign expect_byte = sync_word[{~pos_ff, 3'b000} +: 8];
   assign skip_dec    = (skip_cnt_ff != 4'd0) ? skip_cnt_ff - 4'd1 : skip_cnt_ff;

   always_comb begin
      pos_in      = pos_ff;
      skipping_in = skipping_ff;
      skip_cnt_in = skip_cnt_ff;
      excess_in   = excess_ff;
      nonzero_in  = nonzero_ff;
      rep_excess  = excess_ff;
      rep_nonzero = nonzero_ff;
      status      = STATUS_FOUND;
      emit        = 1'b0;

      if (item.end_of_input) begin
         emit = 1'b1;
         if (skipping_ff) begin
            status = STATUS_END_SKIP;
         end else begin
            // partial attempt counts as excess
            status      = STATUS_END_HUNT;
            rep_excess  = sat_add(excess_ff, {1'b0, pos_ff});
            rep_nonzero = sat_add(nonzero_ff, matched_nonzero(sync_word, pos_ff));
         end
      end else if (skipping_ff) begin
         skip_cnt_in = skip_dec;
         if (skip_dec == 4'd0) begin
            emit = 1'b1;
         end
      end else if (item.data_byte == expect_byte) begin
         if (pos_ff == 2'd3) begin
            pos_in = 2'd0;
            if (header_skip == 4'd0) begin
               emit = 1'b1;
            end else begin
               skipping_in = 1'b1;
               skip_cnt_in = header_skip;
            end
         end else begin
            pos_in = pos_ff + 2'd1;
         end
      end else begin
         // mismatch drops the attempt and this byte
         excess_in  = sat_add(excess_ff, {1'b0, pos_ff} + 3'd1);
         nonzero_in = sat_add(nonzero_ff, matched_nonzero(sync_word, pos_ff)
                              + {2'b00, item.data_byte != 8'd0});
         pos_in     = 2'd0;
      end

      if (emit) begin
         pos_in      = 2'd0;
         skipping_in = 1'b0;
         skip_cnt_in = 4'd0;
         excess_in   = '0;
         nonzero_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= 2'd0;
         skipping_ff <= 1'b0;
         skip_cnt_ff <= 4'd0;
         excess_ff   <= '0;
         nonzero_ff  <= '0;
      end else if (advance) begin
         pos_ff      <= pos_in;
         skipping_ff <= skipping_in;
         skip_cnt_ff <= skip_cnt_in;
         excess_ff   <= excess_in;
         nonzero_ff  <= nonzero_in;
      end
   end

   assign result.status         = status;
   assign result.excess_bytes   = report_sat(rep_excess);
   assign result.excess_nonzero = report_sat(rep_nonzero);

   assign hunt_state.skipping       = skipping_ff;
   assign hunt_state.match_position = pos_ff;

endmodule

// ===== hw/rtl/swh_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swh_out_stage
// result register toward the consumer
// ----------------------------------------------------------------------------
module swh_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  swh_pkg::result_type load_result,
   output logic                out_valid,
   input  logic                out_ready,
   output swh_pkg::result_type out_result
);
   import swh_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff;

   assign valid_in = load ? 1'b1 : ((valid_ff && out_ready) ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= load_result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync word hunter testbench
// streams bytes and end markers into the hunter and checks every report
// against an in-bench predictor of the hunt, skip and count rules; runs a
// short directed sequence, then random framed streams under several sync
// words and skip lengths, with random idling on both sides and a long
// receiver hold-off
// ----------------------------------------------------------------------------

module testbench;

   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1900;
   localparam int PHASES       = 8;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;     // [7:0] data_byte
   logic        req_tuser = 1'b0;     // [0] end_of_input
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;            // [31:0] excess_bytes, [63:32] excess_nonzero
   logic [1:0]  rsp_tuser;            // [1:0] status
   logic        csr_wen = 1'b0;
   logic        csr_index = 1'b0;
   logic [31:0] csr_wdata = 32'd0;

   sync_word_hunter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // bytes waiting to be offered, reports waiting to come out
   swh_pkg::item_type   byte_queue[$];
   swh_pkg::result_type report_queue[$];

   // predictor copy of the registers and the hunt state
   logic [31:0] hunt_word = swh_pkg::SYNC_WORD_RESET;
   logic [3:0]  skip_len = 4'd0;
   logic [1:0]  match_pos = 2'd0;
   logic        skip_active = 1'b0;
   logic [3:0]  skip_left = 4'd0;
   logic [31:0] seen_excess = 32'd0;
   logic [31:0] seen_nonzero = 32'd0;

   // pacing knobs, changed by the stimulus process between edges
   bit send_pace = 1'b0;
   bit recv_pace = 1'b0;
   logic hold_pulse = 1'b0;
   int   hold_left;
   int   send_gap;
   int   rsp_wait;

   int errors = 0;
   int cycles = 0;
   int items_queued = 0;

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // saturating counter add
   function automatic logic [31:0] bump(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // sync byte expected at a position; position 0 sits in the top byte
   function automatic logic [7:0] sync_byte_at(logic [1:0] pos);
      return hunt_word[8*(3 - pos) +: 8];
   endfunction

   // nonzero sync bytes among the first n of the current word
   function automatic logic [31:0] nonzero_prefix(logic [1:0] n);
      logic [31:0] c;
      c = 32'd0;
      for (int i = 0; i < 4; i++) begin
         if (i < int'(n) && sync_byte_at(2'(i)) != 8'd0) c = c + 32'd1;
      end
      return c;
   endfunction

   // build a report and return to hunting with cleared counts
   function automatic swh_pkg::result_type close_report(swh_pkg::status_type st);
      swh_pkg::result_type rep;
      rep.status = st;
      rep.excess_bytes = seen_excess;
      rep.excess_nonzero = seen_nonzero;
      seen_excess = 32'd0;
      seen_nonzero = 32'd0;
      match_pos = 2'd0;
      skip_active = 1'b0;
      skip_left = 4'd0;
      return rep;
   endfunction

   // one stream item through the hunt; returns 1 when a report comes out
   function automatic bit advance_hunt(input swh_pkg::item_type it,
                                       output swh_pkg::result_type rep);
      rep = '0;
      if (it.end_of_input) begin
         if (skip_active) begin
            rep = close_report(swh_pkg::STATUS_END_SKIP);
         end else begin
            // a partial attempt is dropped into the counts
            seen_excess = bump(seen_excess, 32'(match_pos));
            seen_nonzero = bump(seen_nonzero, nonzero_prefix(match_pos));
            rep = close_report(swh_pkg::STATUS_END_HUNT);
         end
         return 1'b1;
      end
      if (skip_active) begin
         if (skip_left != 4'd0) skip_left = skip_left - 4'd1;
         if (skip_left == 4'd0) begin
            rep = close_report(swh_pkg::STATUS_FOUND);
            return 1'b1;
         end
         return 1'b0;
      end
      if (it.data_byte == sync_byte_at(match_pos)) begin
         if (match_pos == 2'd3) begin
            match_pos = 2'd0;
            if (skip_len == 4'd0) begin
               rep = close_report(swh_pkg::STATUS_FOUND);
               return 1'b1;
            end
            skip_active = 1'b1;
            skip_left = skip_len;
            return 1'b0;
         end
         match_pos = match_pos + 2'd1;
         return 1'b0;
      end
      // mismatch drops the whole attempt including this byte
      seen_excess = bump(seen_excess, 32'(match_pos) + 32'd1);
      seen_nonzero = bump(seen_nonzero,
                          nonzero_prefix(match_pos) + 32'(it.data_byte != 8'd0));
      match_pos = 2'd0;
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------------
   // sender: offers queued items, predicts on every accepted one
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : sender
      swh_pkg::item_type   taken;
      swh_pkg::item_type   next_item;
      swh_pkg::result_type rep;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            taken.data_byte = req_tdata;
            taken.end_of_input = req_tuser;
            if (advance_hunt(taken, rep)) report_queue.push_back(rep);
         end
         // free to change what is offered
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (byte_queue.size() != 0) begin
               next_item = byte_queue.pop_front();
               req_tdata <= next_item.data_byte;
               req_tuser <= next_item.end_of_input;
               req_tvalid <= 1'b1;
               send_gap <= send_pace ? $urandom_range(0, 10) : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver: random stall per report, plus the long hold-off
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : hold_counter
      if (reset) hold_left <= 0;
      else if (hold_pulse) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin : receiver
      int wait_next;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) wait_next = recv_pace ? $urandom_range(0, 10) : 0;
         else wait_next = (rsp_wait != 0) ? rsp_wait - 1 : 0;
         rsp_wait <= wait_next;
         rsp_tready <= (wait_next == 0) && (hold_left == 0);
      end
   end

   // ---------------------------------------------------------------------
   // report checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : report_check
      swh_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (report_queue.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected report: status %0d bytes %0d nonzero %0d",
                        rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32]);
         end else begin
            want = report_queue.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata[31:0] !== want.excess_bytes ||
                rsp_tdata[63:32] !== want.excess_nonzero) begin
               errors++;
               if (errors <= 10)
                  $display("report mismatch: expected status %0d bytes %0d nonzero %0d, got status %0d bytes %0d nonzero %0d",
                           want.status, want.excess_bytes, want.excess_nonzero,
                           rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32]);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin : watchdog
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   task automatic push_item(logic [7:0] value, logic eoi);
      swh_pkg::item_type it;
      it.data_byte = value;
      it.end_of_input = eoi;
      byte_queue.push_back(it);
      items_queued++;
   endtask

   // register write; the predictor copy follows at once since nothing is in flight
   task automatic write_reg(swh_pkg::csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == swh_pkg::CSR_SYNC_WORD) hunt_word = value;
      else skip_len = value[3:0];
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // all items taken, all reports in, pipeline flushed
   task automatic wait_quiet();
      do @(negedge clock);
      while (byte_queue.size() != 0 || req_tvalid || report_queue.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         2: return sync_byte_at(2'($urandom_range(0, 3)));
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic push_sync(int n);
      for (int i = 0; i < n; i++) push_item(sync_byte_at(2'(i)), 1'b0);
   endtask

   // junk, maybe a broken attempt, then a sync word and header or an end marker
   task automatic add_frame();
      int junk;
      int kind;
      int cut;
      junk = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 4);
      repeat (junk) push_item(noise_byte(), 1'b0);
      if ($urandom_range(0, 2) == 0) begin
         push_sync($urandom_range(1, 3));
         push_item(noise_byte(), 1'b0);
      end
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         // end while hunting, often right after a partial attempt
         push_sync($urandom_range(0, 3));
         push_item(8'($urandom), 1'b1);
      end else begin
         push_sync(4);
         if (kind == 1 && skip_len != 4'd0) begin
            cut = $urandom_range(0, int'(skip_len) - 1);
            repeat (cut) push_item(8'($urandom), 1'b0);
            push_item(8'($urandom), 1'b1);
         end else begin
            repeat (int'(skip_len)) push_item(8'($urandom), 1'b0);
         end
      end
      if ($urandom_range(0, 19) == 0) push_item(8'($urandom), 1'b1);
   endtask

   initial begin : stimulus
      logic [31:0] word;
      logic [31:0] skip;
      int target;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: registers at reset values, so zero skip and the default word
      write_reg(swh_pkg::CSR_SYNC_WORD, swh_pkg::SYNC_WORD_RESET);
      write_reg(swh_pkg::CSR_HEADER_SKIP, 32'd0);
      // extremes, then a restart after the mismatching second byte, then a match
      push_item(8'h00, 1'b0);
      push_item(8'hFF, 1'b0);
      push_item(8'h35, 1'b0);
      push_item(8'h35, 1'b0);
      push_item(8'h53, 1'b0);
      push_sync(4);
      // end while hunting with a partial attempt pending
      push_sync(2);
      push_item(8'hFF, 1'b1);
      wait_quiet();
      // end during the longest skip
      write_reg(swh_pkg::CSR_HEADER_SKIP, 32'd15);
      push_sync(4);
      push_item(8'hFF, 1'b1);
      wait_quiet();
      // skip length latched at the match; a later write must not change it
      write_reg(swh_pkg::CSR_HEADER_SKIP, 32'd2);
      push_sync(4);
      wait_quiet();
      write_reg(swh_pkg::CSR_HEADER_SKIP, 32'd15);
      push_item(8'h00, 1'b0);
      push_item(8'hFF, 1'b0);
      wait_quiet();
      // new word under a pending partial attempt: nonzero test uses the new word
      push_sync(2);
      wait_quiet();
      write_reg(swh_pkg::CSR_SYNC_WORD, 32'h00FF_00AA);
      push_item(8'h00, 1'b1);
      wait_quiet();

      // random phases over several register settings
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: word = swh_pkg::SYNC_WORD_RESET;
            1: word = 32'h0000_0000;
            2: word = 32'hFFFF_FFFF;
            3: word = 32'h3535_3535;
            4: word = 32'hAA00_AA00;
            default: word = $urandom;
         endcase
         case (p)
            0: skip = 32'd0;
            1: skip = 32'd15;
            2: skip = 32'd1;
            3: skip = 32'd8;
            4: skip = 32'hFFFF_FFF0;   // upper bits dropped, skip of zero
            default: skip = $urandom;
         endcase
         write_reg(swh_pkg::CSR_SYNC_WORD, word);
         write_reg(swh_pkg::CSR_HEADER_SKIP, skip);
         @(negedge clock);
         target = items_queued + RANDOM_ITEMS / PHASES;
         if (p == 0) begin
            // receiver holds off while the sender keeps offering
            send_pace = 1'b0;
            recv_pace = 1'b0;
            @(posedge clock);
            hold_pulse <= 1'b1;
            @(posedge clock);
            hold_pulse <= 1'b0;
            @(negedge clock);
         end
         while (items_queued < target) begin
            if ($urandom_range(0, 7) == 0) begin
               send_pace = $urandom_range(0, 1);
               recv_pace = $urandom_range(0, 1);
            end
            add_frame();
            // keep the queue short so pace changes land mid-stream
            while (byte_queue.size() > 16) @(negedge clock);
         end
         wait_quiet();
      end

      repeat (20) @(negedge clock);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
